FILE: sv/lru_page_replacement_assert.svh
// ----------------------------------------------------------------------------
// lru page replacement assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// general property, disabled while rst_ni is low
`define LRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define LRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// Types and fixed field widths for the lru page replacement block.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int CFG_W         = 5;
  localparam int PAGE_FIELD_W  = 16;
  localparam int FRAME_INDEX_W = 4;
  localparam int FAULT_W       = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } lru_state_e;

  typedef struct packed {
    logic                     hit;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [PAGE_FIELD_W-1:0]  evicted_page;
    logic [FAULT_W-1:0]       fault_count;
    logic                     string_done;
  } result_t;

endpackage

FILE: sv/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru page replacement
// Page frame table with exact recency ranks and least recently used eviction.
// ----------------------------------------------------------------------------
// One page reference is taken per item and one result item comes back. The
// block handles one item at a time: a scan walks the active frames one a
// cycle through the page table's single registered read port, while one
// compare step checks for a hit, the first empty frame and the oldest frame;
// a rank update step and an output load step follow. The next item is taken
// while a finished result still waits on out_stall_i. A frame count of zero
// acts as one, and counts above MAX_FRAMES act as MAX_FRAMES; a write to the
// count takes effect from the next item. An item marked last_reference clears
// the table and the fault count after its result.
module lru_page_replacement #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lru_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [lru_pkg::PAGE_FIELD_W-1:0]     page_number_i,
  input  logic                                 last_reference_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 hit_o,
  output logic [lru_pkg::FRAME_INDEX_W-1:0]    frame_index_o,
  output logic                                 evicted_valid_o,
  output logic [lru_pkg::PAGE_FIELD_W-1:0]     evicted_page_o,
  output logic [lru_pkg::FAULT_W-1:0]          fault_count_o,
  output logic                                 string_done_o
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W = (CNT_W > lru_pkg::CFG_W) ? CNT_W : lru_pkg::CFG_W;

  lru_pkg::lru_state_e state_q, state_d;

  logic [lru_pkg::CFG_W-1:0] cfg_q;
  logic [PAGE_BITS-1:0]      page_q;
  logic                      last_q;
  logic [CNT_W-1:0]          active_q;
  logic [CNT_W-1:0]          idx_q;
  logic                      pvld_q;
  logic [IDX_W-1:0]          pidx_q;

  logic                      hit_found_q;
  logic [IDX_W-1:0]          hit_slot_q;
  logic [IDX_W-1:0]          hit_rank_q;
  logic                      empty_found_q;
  logic [IDX_W-1:0]          empty_slot_q;
  logic [IDX_W-1:0]          lru_slot_q;
  logic [IDX_W-1:0]          lru_rank_q;
  logic [PAGE_BITS-1:0]      lru_page_q;

  logic [MAX_FRAMES-1:0]     valid_q;
  logic [IDX_W-1:0]          rank_q [MAX_FRAMES];
  logic [IDX_W-1:0]          rank_d [MAX_FRAMES];
  logic [lru_pkg::FAULT_W-1:0] faults_q;
  logic [lru_pkg::FAULT_W-1:0] faults_next;

  logic [PAGE_BITS-1:0]      mem [MAX_FRAMES];
  logic [PAGE_BITS-1:0]      rd_data_q;

  lru_pkg::result_t          res_q;
  lru_pkg::result_t          out_q;
  logic                      out_valid_q;

  logic                      in_accept;
  logic                      out_free;
  logic                      scan_issue;
  logic                      cur_valid;
  logic                      cur_match;
  logic [IDX_W-1:0]          cur_rank;
  logic [CMP_W-1:0]          cfg_ext;
  logic [CMP_W-1:0]          act_ext;
  logic [CNT_W-1:0]          active_in;
  logic [IDX_W-1:0]          slot;
  logic                      slot_was_valid;
  logic [IDX_W-1:0]          slot_rank;
  logic                      evict;

  // ---------------------------------------------------------------- control
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign scan_issue = (state_q == lru_pkg::ST_SCAN) && (idx_q < active_q);

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      lru_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = lru_pkg::ST_SCAN;
      end
      lru_pkg::ST_SCAN: begin
        // last frame is compared in the cycle after its read is issued
        if (!scan_issue) state_d = lru_pkg::ST_UPDATE;
      end
      lru_pkg::ST_UPDATE: begin
        state_d = lru_pkg::ST_OUT;
      end
      lru_pkg::ST_OUT: begin
        if (out_free) state_d = lru_pkg::ST_IDLE;
      end
      default: state_d = lru_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lru_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // clamp the frame count into 1..MAX_FRAMES
  always_comb begin
    cfg_ext = CMP_W'(cfg_q);
    if (cfg_ext == '0) begin
      act_ext = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_FRAMES)) begin
      act_ext = CMP_W'(MAX_FRAMES);
    end else begin
      act_ext = cfg_ext;
    end
    active_in = CNT_W'(act_ext);
  end

  // ------------------------------------------------------------ compare step
  assign cur_valid = valid_q[pidx_q];
  assign cur_rank  = rank_q[pidx_q];
  assign cur_match = cur_valid && (rd_data_q == page_q);

  // ------------------------------------------------------------ update step
  always_comb begin
    evict          = !hit_found_q && !empty_found_q;
    slot_was_valid = hit_found_q || evict;
    slot_rank      = hit_found_q ? hit_rank_q : lru_rank_q;
    priority if (hit_found_q) begin
      slot = hit_slot_q;
    end else if (empty_found_q) begin
      slot = empty_slot_q;
    end else begin
      slot = lru_slot_q;
    end
    if (!hit_found_q && (faults_q != '1)) begin
      faults_next = faults_q + lru_pkg::FAULT_W'(1);
    end else begin
      faults_next = faults_q;
    end
  end

  // frames younger than the touched one age by one; an empty frame is oldest
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_d[i] = rank_q[i];
      if (IDX_W'(i) == slot) begin
        rank_d[i] = '0;
      end else if (valid_q[i] && (!slot_was_valid || (rank_q[i] < slot_rank))) begin
        rank_d[i] = rank_q[i] + IDX_W'(1);
      end
    end
  end

  // -------------------------------------------------------- state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= lru_pkg::FRAMES_RESET;
      valid_q     <= '0;
      faults_q    <= '0;
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) cfg_q <= cfg_data_i;
      pvld_q <= scan_issue;
      if (state_q == lru_pkg::ST_UPDATE) begin
        if (last_q) begin
          valid_q  <= '0;
          faults_q <= '0;
          for (int i = 0; i < MAX_FRAMES; i++) begin
            rank_q[i] <= '0;
          end
        end else begin
          valid_q[slot] <= 1'b1;
          faults_q      <= faults_next;
          for (int i = 0; i < MAX_FRAMES; i++) begin
            rank_q[i] <= rank_d[i];
          end
        end
      end
      if ((state_q == lru_pkg::ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      page_q        <= PAGE_BITS'(page_number_i);
      last_q        <= last_reference_i;
      active_q      <= active_in;
      idx_q         <= '0;
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
    end
    if (scan_issue) begin
      idx_q  <= idx_q + CNT_W'(1);
      pidx_q <= idx_q[IDX_W-1:0];
    end
    if ((state_q == lru_pkg::ST_SCAN) && pvld_q) begin
      if (cur_match && !hit_found_q) begin
        hit_found_q <= 1'b1;
        hit_slot_q  <= pidx_q;
        hit_rank_q  <= cur_rank;
      end
      if (!cur_valid && !empty_found_q) begin
        empty_found_q <= 1'b1;
        empty_slot_q  <= pidx_q;
      end
      // strict compare keeps the lowest index; frame 0 seeds the search
      if ((pidx_q == '0) || (cur_rank > lru_rank_q)) begin
        lru_slot_q <= pidx_q;
        lru_rank_q <= cur_rank;
        lru_page_q <= rd_data_q;
      end
    end
    if (state_q == lru_pkg::ST_UPDATE) begin
      res_q.hit           <= hit_found_q;
      res_q.frame_index   <= lru_pkg::FRAME_INDEX_W'(slot);
      res_q.evicted_valid <= evict;
      res_q.evicted_page  <= evict ? lru_pkg::PAGE_FIELD_W'(lru_page_q) : '0;
      res_q.fault_count   <= faults_next;
      res_q.string_done   <= last_q;
    end
    if ((state_q == lru_pkg::ST_OUT) && out_free) begin
      out_q <= res_q;
    end
  end

  // page table, one write and one registered read
  always_ff @(posedge clk_i) begin
    if ((state_q == lru_pkg::ST_UPDATE) && !hit_found_q) begin
      mem[slot] <= page_q;
    end
    rd_data_q <= mem[idx_q[IDX_W-1:0]];
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_q.hit;
  assign frame_index_o   = out_q.frame_index;
  assign evicted_valid_o = out_q.evicted_valid;
  assign evicted_page_o  = out_q.evicted_page;
  assign fault_count_o   = out_q.fault_count;
  assign string_done_o   = out_q.string_done;

endmodule

FILE: sv/lru_chk.sv
// ----------------------------------------------------------------------------
// lru checker
// Port-level assertions for the lru page replacement block, bound to the top.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_assert.svh"

module lru_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_we_i,
  input logic [lru_pkg::CFG_W-1:0]         cfg_data_i,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [lru_pkg::PAGE_FIELD_W-1:0]  page_number_i,
  input logic                              last_reference_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              hit_o,
  input logic [lru_pkg::FRAME_INDEX_W-1:0] frame_index_o,
  input logic                              evicted_valid_o,
  input logic [lru_pkg::PAGE_FIELD_W-1:0]  evicted_page_o,
  input logic [lru_pkg::FAULT_W-1:0]       fault_count_o,
  input logic                              string_done_o
);

  // a stalled result item holds
  `LRU_ASSERT(a_out_hold, (out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o) && $stable(frame_index_o) && $stable(evicted_valid_o) && $stable(evicted_page_o) && $stable(fault_count_o) && $stable(string_done_o)), "stalled result item changed")

  // the block is busy right after it takes an item
  `LRU_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o |=> in_stall_o), "item accepted while busy")

  `LRU_ASSERT_IMP(a_hit_no_evict, out_valid_o, !(hit_o && evicted_valid_o), "hit with eviction")

  `LRU_ASSERT_IMP(a_evict_page_zero, out_valid_o && !evicted_valid_o, evicted_page_o == '0, "evicted page set without eviction")

  `LRU_ASSERT_IMP(a_fault_counted, out_valid_o && !hit_o, fault_count_o != '0, "fault not counted")

endmodule

bind lru_page_replacement lru_chk u_lru_chk (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru page replacement testbench
// Drives page references through the valid/stall handshake under several
// frame counts and idle patterns. A scoreboard keeps its own frame table with
// exact recency ranks, predicts each result item and checks it field by field.
// ----------------------------------------------------------------------------

class lru_scoreboard;
  localparam int NUM_FRAMES = 16;

  logic [lru_pkg::PAGE_FIELD_W-1:0] frame_page[NUM_FRAMES];
  bit                               frame_used[NUM_FRAMES];
  int unsigned                      frame_age[NUM_FRAMES];
  bit [lru_pkg::FAULT_W-1:0]        fault_total;
  bit [lru_pkg::CFG_W-1:0]          frames_cfg;
  lru_pkg::result_t                 expected_q[$];
  int                               errors;

  function new();
    wipe_table();
    frames_cfg = lru_pkg::FRAMES_RESET;
    errors = 0;
  endfunction

  function void wipe_table();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_page[i] = '0;
      frame_used[i] = 1'b0;
      frame_age[i]  = 0;
    end
    fault_total = '0;
  endfunction

  function void write_frames(bit [lru_pkg::CFG_W-1:0] value);
    frames_cfg = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // work out the result of one accepted reference and queue it
  function void note_ref(logic [lru_pkg::PAGE_FIELD_W-1:0] page, logic last);
    int               active;
    int               slot;
    bit               found;
    bit               was_used;
    int unsigned      old_age;
    lru_pkg::result_t res;

    active = (frames_cfg == 0) ? 1 :
             (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : int'(frames_cfg);
    res = '0;
    slot = 0;
    found = 1'b0;
    for (int i = 0; i < active && !found; i++) begin
      if (frame_used[i] && frame_page[i] == page) begin
        found = 1'b1;
        slot = i;
      end
    end
    res.hit = found;
    if (!found) begin
      for (int i = 0; i < active && !found; i++) begin
        if (!frame_used[i]) begin
          found = 1'b1;
          slot = i;
        end
      end
      if (!found) begin
        slot = 0;
        for (int i = 1; i < active; i++) begin
          if (frame_age[i] > frame_age[slot]) slot = i;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = frame_page[slot];
      end
      frame_page[slot] = page;
      if (fault_total != '1) fault_total++;
    end
    // promote slot to most recent; an empty frame is older than all valid ones
    was_used = frame_used[slot];
    old_age  = frame_age[slot];
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (i != slot && frame_used[i] && (!was_used || frame_age[i] < old_age))
        frame_age[i]++;
    end
    frame_age[slot]  = 0;
    frame_used[slot] = 1'b1;

    res.frame_index = slot[lru_pkg::FRAME_INDEX_W-1:0];
    res.fault_count = fault_total;
    res.string_done = last;
    expected_q.push_back(res);
    if (last) wipe_table();
  endfunction

  function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(lru_pkg::result_t act);
    lru_pkg::result_t exp_r;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result item: expected none, actual %0h", $time, act);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    check_field("hit", exp_r.hit, act.hit);
    check_field("frame_index", exp_r.frame_index, act.frame_index);
    check_field("evicted_valid", exp_r.evicted_valid, act.evicted_valid);
    check_field("evicted_page", exp_r.evicted_page, act.evicted_page);
    check_field("fault_count", exp_r.fault_count, act.fault_count);
    check_field("string_done", exp_r.string_done, act.string_done);
  endfunction
endclass

module tb;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 200;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [lru_pkg::CFG_W-1:0]         cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [lru_pkg::PAGE_FIELD_W-1:0]  page_number_i;
  logic                              last_reference_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic                              hit_o;
  logic [lru_pkg::FRAME_INDEX_W-1:0] frame_index_o;
  logic                              evicted_valid_o;
  logic [lru_pkg::PAGE_FIELD_W-1:0]  evicted_page_o;
  logic [lru_pkg::FAULT_W-1:0]       fault_count_o;
  logic                              string_done_o;

  lru_scoreboard sb = new();

  int                               idle_pct;
  int                               stall_pct;
  bit                               hold_req;
  int                               hold_left;
  logic [lru_pkg::PAGE_FIELD_W-1:0] page_pool[24];
  int                               pool_size;

  lru_page_replacement #(
    .MAX_FRAMES(16),
    .PAGE_BITS (16)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .page_number_i   (page_number_i),
    .last_reference_i(last_reference_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o),
    .string_done_o   (string_done_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // observe accepted items and register writes at the clock edge
  always @(posedge clk_i) begin
    lru_pkg::result_t act;
    if (rst_ni) begin
      if (cfg_we_i) sb.write_frames(cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_ref(page_number_i, last_reference_i);
      if (out_valid_o && !out_stall_i) begin
        act.hit           = hit_o;
        act.frame_index   = frame_index_o;
        act.evicted_valid = evicted_valid_o;
        act.evicted_page  = evicted_page_o;
        act.fault_count   = fault_count_o;
        act.string_done   = string_done_o;
        sb.check_result(act);
      end
    end
  end

  // result side: random stall, or a long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("lru_page_replacement test failed");
    $finish;
  end

  task automatic send_ref(logic [lru_pkg::PAGE_FIELD_W-1:0] page, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    page_number_i    <= page;
    last_reference_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and wait for every outstanding result item
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_frames(logic [lru_pkg::CFG_W-1:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic new_pool(int active);
    pool_size = (active + 3 > 24) ? 24 : active + 3;
    for (int i = 0; i < 24; i++) page_pool[i] = lru_pkg::PAGE_FIELD_W'($urandom);
    if ($urandom_range(1)) page_pool[0] = '0;
    if ($urandom_range(1)) page_pool[1] = '1;
  endtask

  function automatic logic [lru_pkg::PAGE_FIELD_W-1:0] pick_page();
    int r;
    r = $urandom_range(99);
    if (r < 80) return page_pool[$urandom_range(pool_size - 1)];
    if (r < 92) return lru_pkg::PAGE_FIELD_W'($urandom);
    return $urandom_range(1) ? '1 : '0;
  endfunction

  initial begin
    logic [lru_pkg::CFG_W-1:0] phase_frames[8];
    int                        active;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    page_number_i    = '0;
    last_reference_i = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_req         = 1'b0;
    pool_size        = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty fill, hit, extremes, end of string at reset frame count
    send_ref(16'h0000, 1'b0);
    send_ref(16'hffff, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hffff, 1'b1);
    // two frames: lru eviction order
    set_frames(5'd2);
    send_ref(16'd5, 1'b0);
    send_ref(16'd6, 1'b0);
    send_ref(16'd5, 1'b0);
    send_ref(16'd7, 1'b0);
    send_ref(16'd6, 1'b0);
    send_ref(16'd0, 1'b1);
    // zero frames acts as one
    set_frames(5'd0);
    send_ref(16'd9, 1'b0);
    send_ref(16'd9, 1'b0);
    send_ref(16'd10, 1'b0);
    // count above the frame table acts as full, written mid-string
    set_frames(5'd31);
    send_ref(16'd10, 1'b0);
    send_ref(16'd1, 1'b0);
    send_ref(16'd2, 1'b0);
    send_ref(16'd3, 1'b0);
    // shrunk set hides frames that still hold pages
    set_frames(5'd2);
    send_ref(16'd3, 1'b0);
    send_ref(16'd2, 1'b0);
    set_frames(5'd16);
    send_ref(16'd3, 1'b0);
    send_ref(16'd2, 1'b0);
    send_ref(16'd4, 1'b1);

    phase_frames = '{5'd16, 5'd4, 5'd1, 5'd8, 5'd31, 5'd0, 5'd17, 5'd16};
    phase_frames[7] = lru_pkg::CFG_W'($urandom_range(2, 15));
    for (int ph = 0; ph < 8; ph++) begin
      set_frames(phase_frames[ph]);
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 53;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 53;
        end
        default: begin
          idle_pct = 18;
          stall_pct = 18;
        end
      endcase
      active = (phase_frames[ph] == 0) ? 1 :
               (phase_frames[ph] > 16) ? 16 : int'(phase_frames[ph]);
      new_pool(active);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long result hold-off while items keep coming
        if (ph == 4 && n == 50) hold_req = 1'b1;
        if (ph == 1 && n == 100) drain();
        if ($urandom_range(49) == 0) new_pool(active);
        send_ref(pick_page(), $urandom_range(29) == 0);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("lru_page_replacement test passed");
    else
      $display("lru_page_replacement test failed");
    $finish;
  end
endmodule
